>>> src/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg - shared definitions for the linear/binary search core
// Action codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int DATA_W    = 32;
	localparam int ACT_W     = 2;
	localparam int POS_W     = 5;
	localparam int DEPTH_DEF = 32;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LINEAR = 2'd2;
	localparam logic [ACT_W-1:0] ACT_BINARY = 2'd3;

	// control for one storage cell
	typedef struct packed {
		logic shift;  // take the neighbor's word
		logic wr;     // load the appended word
	} cell_ctl_t;

endpackage

>>> src/lbs_cell.sv
// ----------------------------------------------------------------------------
// lbs_cell - one storage cell of the element ring
// Holds one element; loads on append, takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module lbs_cell (
	input  logic                                clk,
	input  lbs_pkg::cell_ctl_t                  ctl,
	input  logic signed [lbs_pkg::DATA_W-1:0]   wr_data,
	input  logic signed [lbs_pkg::DATA_W-1:0]   nbr_data,
	output logic signed [lbs_pkg::DATA_W-1:0]   elem
);

	logic signed [lbs_pkg::DATA_W-1:0] elem_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			elem_q <= wr_data;
		end else if (ctl.shift) begin
			elem_q <= nbr_data;
		end
	end

	assign elem = elem_q;

endmodule

>>> src/linear_and_binary_search_core.sv
// ----------------------------------------------------------------------------
// linear_and_binary_search_core - element store with linear and binary search
// Ring of storage cells rotated past a single compare point at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive action/value and raise start; the word is taken
//   at a clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with found, position and
//   store_full valid. The receiver cannot stall; it must take the word then.
//   Clear and append: done is raised in the cycle after the command; busy stays low,
//   so a new command may follow on the very next cycle.
//   Linear search: the ring rotates one full turn, with one
//   compare per cycle at the head cell; done follows the last rotation.
//   Binary search: the ring keeps rotating; a probe is made when the midpoint
//   index reaches the head. The search ends at the first turn boundary after
//   the halving is over. The ring rotates one cell per cycle while busy.
//   The ring is always back home (index 0 at cell 0) when busy falls.
//   Reset: element count returns to zero, the controller goes idle, done
//   is low. Element contents are not cleared; only appended entries are read.
// ----------------------------------------------------------------------------
module linear_and_binary_search_core #(
	parameter int DEPTH = lbs_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lbs_pkg::ACT_W-1:0]           action,
	input  logic signed [lbs_pkg::DATA_W-1:0]   value,
	output logic                                busy,
	output logic                                done,
	output logic                                found,
	output logic [lbs_pkg::POS_W-1:0]           position,
	output logic                                store_full
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// lo/hi bounds: signed, room for lo+hi and hi = -1
	localparam int SW    = CNT_W + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LIN  = 2'd1;
	localparam logic [1:0] ST_BIN  = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [1:0]                        state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [IDX_W-1:0]                  head_q;    // index currently at cell 0
	logic signed [lbs_pkg::DATA_W-1:0] key_q;
	logic signed [SW-1:0]              lo_q;
	logic signed [SW-1:0]              hi_q;
	logic                              hit_q;
	logic [lbs_pkg::POS_W-1:0]         hpos_q;

	logic                              done_q;
	logic                              found_q;
	logic [lbs_pkg::POS_W-1:0]         position_q;
	logic                              store_full_q;

	logic                              accept;
	logic                              rotate;
	logic                              room;
	logic                              last;
	logic signed [lbs_pkg::DATA_W-1:0] head_elem;
	logic signed [lbs_pkg::DATA_W-1:0] elem [DEPTH];

	// search step, linear and binary
	logic                              active;
	logic signed [SW-1:0]              mid;
	logic                              probe;
	logic                              lin_hit;
	logic                              hit_n;
	logic [lbs_pkg::POS_W-1:0]         hpos_n;
	logic signed [SW-1:0]              lo_n;
	logic signed [SW-1:0]              hi_n;
	logic                              finish;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign rotate   = busy;
	assign room     = (count_q < DEPTH_CNT);
	assign last     = (head_q == LAST_IDX);
	assign head_elem = elem[0];

	// ---- cell ring: cell i takes from cell i+1, last cell from cell 0 ----
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lbs_pkg::cell_ctl_t ctl;

		assign ctl.shift = rotate;
		assign ctl.wr    = accept && (action == lbs_pkg::ACT_APPEND) && room
		                   && (count_q[IDX_W-1:0] == IDX_W'(i));

		lbs_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.wr_data  (value),
			.nbr_data (elem[(i + 1) % DEPTH]),
			.elem     (elem[i])
		);
	end

	// ---- compare at the head cell ----
	assign active  = (lo_q <= hi_q) && !hit_q;
	assign mid     = (lo_q + hi_q) >>> 1;
	assign probe   = (state_q == ST_BIN) && active && (mid[IDX_W-1:0] == head_q);
	assign lin_hit = (state_q == ST_LIN) && !hit_q && (CNT_W'(head_q) < count_q)
	                 && (head_elem == key_q);

	always_comb begin
		hit_n  = hit_q;
		hpos_n = hpos_q;
		lo_n   = lo_q;
		hi_n   = hi_q;
		if (lin_hit) begin
			hit_n  = 1'b1;
			hpos_n = lbs_pkg::POS_W'(head_q);
		end
		if (probe) begin
			if (head_elem == key_q) begin
				hit_n  = 1'b1;
				hpos_n = lbs_pkg::POS_W'(head_q);
			end else if (key_q > head_elem) begin
				lo_n = mid + SW'(1);
			end else begin
				hi_n = mid - SW'(1);
			end
		end
	end

	// end on a turn boundary so the ring is home again
	always_comb begin
		case (state_q)
			ST_LIN:  finish = last;
			ST_BIN:  finish = last && (hit_n || (lo_n > hi_n));
			default: finish = 1'b0;
		endcase
	end

	// ---- controller ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			hit_q        <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			position_q   <= '0;
			store_full_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				head_q <= '0;
				hit_q  <= 1'b0;
				case (action)
					lbs_pkg::ACT_CLEAR: begin
						count_q      <= '0;
						done_q       <= 1'b1;
						found_q      <= 1'b0;
						position_q   <= '0;
						store_full_q <= 1'b0;
					end
					lbs_pkg::ACT_APPEND: begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						done_q       <= 1'b1;
						found_q      <= 1'b0;
						position_q   <= '0;
						store_full_q <= !room;
					end
					lbs_pkg::ACT_LINEAR: begin
						state_q <= ST_LIN;
					end
					default: begin
						state_q <= ST_BIN;
					end
				endcase
			end else if (busy) begin
				hit_q  <= hit_n;
				head_q <= last ? '0 : head_q + IDX_W'(1);
				if (finish) begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					found_q      <= hit_n;
					position_q   <= hit_n ? hpos_n : '0;
					store_full_q <= 1'b0;
				end
			end
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= value;
			lo_q   <= '0;
			hi_q   <= $signed({{(SW - CNT_W){1'b0}}, count_q}) - SW'(1);
			hpos_q <= '0;
		end else if (busy) begin
			lo_q   <= lo_n;
			hi_q   <= hi_n;
			hpos_q <= hpos_n;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign position   = position_q;
	assign store_full = store_full_q;

endmodule

>>> src/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker - port-level checks for the search core
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lbs_pkg::ACT_W-1:0]           action,
	input  logic                                busy,
	input  logic                                done,
	input  logic                                found,
	input  logic [lbs_pkg::POS_W-1:0]           position,
	input  logic                                store_full
);

	// a result word never overlaps a running search
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// clear and append answer on the next cycle without going busy
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == lbs_pkg::ACT_CLEAR || action == lbs_pkg::ACT_APPEND))
		|=> (done && !busy && !found))
		else $error("clear/append did not finish in one cycle");

	// a search command goes busy
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == lbs_pkg::ACT_LINEAR || action == lbs_pkg::ACT_BINARY))
		|=> busy)
		else $error("search did not start");

	// end of a search always delivers a word with no full flag
	a_search_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && !store_full))
		else $error("search ended without result");

	// position is zero unless something was found
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position == '0))
		else $error("nonzero position without a match");

endmodule

bind linear_and_binary_search_core lbs_checker u_lbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.action     (action),
	.busy       (busy),
	.done       (done),
	.found      (found),
	.position   (position),
	.store_full (store_full)
);
